// ===== src/wdd_pkg.sv =====
// Shared types, request codes and helper function of the word dictionary decoder.
package wdd_pkg;

	localparam int IDX_W  = 12;
	localparam int POS_W  = 6;
	localparam int LEN_W  = 6;
	localparam int BYTE_W = 8;

	localparam int MAX_WORD_BYTES_DEF = 63;
	localparam int SMALL_ENTRIES_DEF  = 256;
	localparam int LARGE_ENTRIES_DEF  = 4096;

	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_SMALL   = 2'd1;
	localparam logic [1:0] REQ_LARGE   = 2'd2;
	localparam logic [1:0] REQ_LITERAL = 2'd3;

	localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'd32;

	typedef struct packed {
		logic [1:0]        req_type;
		logic              dict_select;
		logic [IDX_W-1:0]  entry_index;
		logic [POS_W-1:0]  byte_pos;
		logic [LEN_W-1:0]  entry_length;
		logic [BYTE_W-1:0] data_byte;
		logic              literal_first;
		logic              literal_last;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_word;
	} rsp_t;

	typedef struct packed {
		logic              small_en;
		logic              large_en;
		logic              byte_en;
		logic [IDX_W-1:0]  idx;
		logic [POS_W-1:0]  pos;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] data;
	} st_wr_t;

	typedef struct packed {
		logic              use_large;
		logic [IDX_W-1:0]  idx;
		logic [POS_W-1:0]  pos;
	} st_rd_t;

	function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h61 && c <= 8'h7a);
	endfunction

endpackage

// ===== src/word_dictionary_decoder_top.sv =====
// Top level of the word dictionary decoder.
//
// Channel   Direction  Handshake                     Payload
// item      in         start high while busy low      req (wdd_pkg::req_t)
// result    out        strobe high for one cycle      rsp (wdd_pkg::rsp_t)
//
// A load item leaves the sequencer idle, and a literal byte gives one result or a space and then the byte.
// A token reads its length and then emits its bytes, a space included, as the space goes out while the first
// byte is read; the registered reads and the one byte per cycle read port of the word store
// set that sequence. An out-of-range token leaves the sequencer idle.
// The stores need no clearing after reset; only the sequencer and the word state are reset.
// Results come from a register and cannot be held off by the receiver.
module word_dictionary_decoder_top #(
	parameter int MAX_WORD_BYTES = wdd_pkg::MAX_WORD_BYTES_DEF,
	parameter int SMALL_ENTRIES  = wdd_pkg::SMALL_ENTRIES_DEF,
	parameter int LARGE_ENTRIES  = wdd_pkg::LARGE_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  wdd_pkg::req_t req,
	output logic          busy,
	output logic          strobe,
	output wdd_pkg::rsp_t rsp
);
	import wdd_pkg::*;

	st_wr_t            wr;
	st_rd_t            rd;
	logic [LEN_W-1:0]  rd_len;
	logic [BYTE_W-1:0] rd_byte;

	wdd_ctrl #(
		.MAX_WORD_BYTES(MAX_WORD_BYTES),
		.SMALL_ENTRIES (SMALL_ENTRIES),
		.LARGE_ENTRIES (LARGE_ENTRIES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.wr     (wr),
		.rd     (rd),
		.rd_len (rd_len),
		.rd_byte(rd_byte),
		.strobe (strobe),
		.rsp    (rsp)
	);

	wdd_store #(
		.SMALL_ENTRIES(SMALL_ENTRIES),
		.LARGE_ENTRIES(LARGE_ENTRIES)
	) u_store (
		.clk    (clk),
		.wr     (wr),
		.rd     (rd),
		.rd_len (rd_len),
		.rd_byte(rd_byte)
	);

endmodule

// ===== src/wdd_store.sv =====
// Small and large word stores with their length tables, registered reads.
module wdd_store #(
	parameter int SMALL_ENTRIES = wdd_pkg::SMALL_ENTRIES_DEF,
	parameter int LARGE_ENTRIES = wdd_pkg::LARGE_ENTRIES_DEF
) (
	input  logic                      clk,
	input  wdd_pkg::st_wr_t           wr,
	input  wdd_pkg::st_rd_t           rd,
	output logic [wdd_pkg::LEN_W-1:0] rd_len,
	output logic [wdd_pkg::BYTE_W-1:0] rd_byte
);
	import wdd_pkg::*;

	localparam int SIW    = $clog2(SMALL_ENTRIES);
	localparam int LIW    = $clog2(LARGE_ENTRIES);
	localparam int STRIDE = 1 << POS_W;

	logic [BYTE_W-1:0] small_bytes [SMALL_ENTRIES*STRIDE];
	logic [LEN_W-1:0]  small_lens  [SMALL_ENTRIES];
	logic [BYTE_W-1:0] large_bytes [LARGE_ENTRIES*STRIDE];
	logic [LEN_W-1:0]  large_lens  [LARGE_ENTRIES];

	logic [31:0]       wr_idx_ext;
	logic [31:0]       rd_idx_ext;
	logic [SIW-1:0]    wr_sidx;
	logic [LIW-1:0]    wr_lidx;
	logic [SIW-1:0]    rd_sidx;
	logic [LIW-1:0]    rd_lidx;
	logic [BYTE_W-1:0] small_byte_q;
	logic [BYTE_W-1:0] large_byte_q;
	logic [LEN_W-1:0]  small_len_q;
	logic [LEN_W-1:0]  large_len_q;
	logic              large_q;

	assign wr_idx_ext = 32'(wr.idx);
	assign rd_idx_ext = 32'(rd.idx);
	assign wr_sidx    = wr_idx_ext[SIW-1:0];
	assign wr_lidx    = wr_idx_ext[LIW-1:0];
	assign rd_sidx    = rd_idx_ext[SIW-1:0];
	assign rd_lidx    = rd_idx_ext[LIW-1:0];

	always_ff @(posedge clk) begin
		if (wr.small_en && wr.byte_en) begin
			small_bytes[{wr_sidx, wr.pos}] <= wr.data;
		end
		small_byte_q <= small_bytes[{rd_sidx, rd.pos}];
	end

	always_ff @(posedge clk) begin
		if (wr.small_en) begin
			small_lens[wr_sidx] <= wr.len;
		end
		small_len_q <= small_lens[rd_sidx];
	end

	always_ff @(posedge clk) begin
		if (wr.large_en && wr.byte_en) begin
			large_bytes[{wr_lidx, wr.pos}] <= wr.data;
		end
		large_byte_q <= large_bytes[{rd_lidx, rd.pos}];
	end

	always_ff @(posedge clk) begin
		if (wr.large_en) begin
			large_lens[wr_lidx] <= wr.len;
		end
		large_len_q <= large_lens[rd_lidx];
		large_q     <= rd.use_large;
	end

	assign rd_len  = large_q ? large_len_q : small_len_q;
	assign rd_byte = large_q ? large_byte_q : small_byte_q;

endmodule

// ===== src/wdd_ctrl.sv =====
// Sequencer that decodes items, steps through stored words and drives the result register.
module wdd_ctrl #(
	parameter int MAX_WORD_BYTES = wdd_pkg::MAX_WORD_BYTES_DEF,
	parameter int SMALL_ENTRIES  = wdd_pkg::SMALL_ENTRIES_DEF,
	parameter int LARGE_ENTRIES  = wdd_pkg::LARGE_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  wdd_pkg::req_t              req,
	output logic                       busy,
	output wdd_pkg::st_wr_t            wr,
	output wdd_pkg::st_rd_t            rd,
	input  logic [wdd_pkg::LEN_W-1:0]  rd_len,
	input  logic [wdd_pkg::BYTE_W-1:0] rd_byte,
	output logic                       strobe,
	output wdd_pkg::rsp_t              rsp
);
	import wdd_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RDLEN = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;
	localparam logic [1:0] ST_LIT   = 2'd3;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD_BYTES);

	logic [1:0]       state_q;
	req_t             req_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic             prev_alnum_q;
	logic             started_q;
	logic             strobe_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             small_ok;
	logic             large_ok;
	logic [LEN_W-1:0] load_len;
	logic [LEN_W-1:0] word_len;
	logic             word_alnum;
	logic             lit_alnum;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign small_ok = 32'(req.entry_index) < 32'(SMALL_ENTRIES);
	assign large_ok = 32'(req.entry_index) < 32'(LARGE_ENTRIES);
	assign load_len = (req.entry_length > MAX_LEN) ? MAX_LEN : req.entry_length;

	always_comb begin
		wr.small_en = accept && (req.req_type == REQ_LOAD) && !req.dict_select && small_ok;
		wr.large_en = accept && (req.req_type == REQ_LOAD) && req.dict_select && large_ok;
		wr.byte_en  = (req.byte_pos < POS_W'(MAX_WORD_BYTES));
		wr.idx      = req.entry_index;
		wr.pos      = req.byte_pos;
		wr.len      = load_len;
		wr.data     = req.data_byte;
	end

	always_comb begin
		if (state_q == ST_IDLE) begin
			rd.use_large = (req.req_type == REQ_LARGE);
			rd.idx       = req.entry_index;
		end else begin
			rd.use_large = (req_q.req_type == REQ_LARGE);
			rd.idx       = req_q.entry_index;
		end
		rd.pos = (state_q == ST_EMIT) ? pos_q + 6'd1 : '0;
	end

	assign word_len   = (rd_len > MAX_LEN) ? MAX_LEN : rd_len;
	assign word_alnum = (word_len != '0) && is_alnum(rd_byte);
	assign lit_alnum  = is_alnum(req.data_byte);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == ST_RDLEN) begin
			len_q <= word_len;
		end
		if (state_q == ST_RDLEN) begin
			pos_q <= '0;
		end else if (state_q == ST_EMIT) begin
			pos_q <= pos_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_alnum_q <= 1'b0;
			started_q    <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_LOAD: begin
								state_q <= ST_IDLE;
							end
							REQ_SMALL, REQ_LARGE: begin
								if ((req.req_type == REQ_SMALL) ? small_ok : large_ok) begin
									state_q <= ST_RDLEN;
								end else begin
									prev_alnum_q <= 1'b0;
								end
							end
							REQ_LITERAL: begin
								started_q <= 1'b1;
								strobe_q  <= 1'b1;
								if (req.literal_first) begin
									prev_alnum_q <= lit_alnum;
								end
								if (req.literal_first && lit_alnum && prev_alnum_q &&
										started_q) begin
									rsp_q.out_byte     <= SPACE_BYTE;
									rsp_q.last_of_word <= 1'b0;
									state_q            <= ST_LIT;
								end else begin
									rsp_q.out_byte     <= req.data_byte;
									rsp_q.last_of_word <= 1'b1;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RDLEN: begin
					prev_alnum_q <= word_alnum;
					if (word_len == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_EMIT;
						if (word_alnum && prev_alnum_q && started_q) begin
							strobe_q           <= 1'b1;
							started_q          <= 1'b1;
							rsp_q.out_byte     <= SPACE_BYTE;
							rsp_q.last_of_word <= 1'b0;
						end
					end
				end
				ST_EMIT: begin
					strobe_q           <= 1'b1;
					started_q          <= 1'b1;
					rsp_q.out_byte     <= rd_byte;
					rsp_q.last_of_word <= (pos_q == len_q - 6'd1);
					if (pos_q == len_q - 6'd1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LIT: begin
					strobe_q           <= 1'b1;
					rsp_q.out_byte     <= req_q.data_byte;
					rsp_q.last_of_word <= 1'b1;
					state_q            <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

endmodule

// ===== src/wdd_checker.sv =====
// Port-level checks of the word dictionary decoder and their binding to the top level.
module wdd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input wdd_pkg::req_t req,
	input logic          busy,
	input logic          strobe,
	input wdd_pkg::rsp_t rsp
);
	import wdd_pkg::*;

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == REQ_LOAD) |=> !strobe)
		else $error("A load item produced a result.");

	a_token_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.req_type == REQ_SMALL || req.req_type == REQ_LARGE))
		|=> !strobe)
		else $error("A token produced a result in the cycle after acceptance.");

	a_literal_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == REQ_LITERAL && !req.literal_first)
		|=> (strobe && rsp.last_of_word && rsp.out_byte == $past(req.data_byte)))
		else $error("A continuing literal byte was not passed straight through.");

	a_word_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !rsp.last_of_word) |=> strobe)
		else $error("The results of one item were not contiguous.");

endmodule

bind word_dictionary_decoder_top wdd_checker u_wdd_checker (.*);

// ===== test/tb_word_dictionary_decoder_top.sv =====
// Self-checking testbench of the word dictionary decoder: directed and random items, predicted text.
`timescale 1ns / 1ps

module tb_word_dictionary_decoder_top;

	import wdd_pkg::*;

	localparam int MAX_BYTES = MAX_WORD_BYTES_DEF;
	localparam int SMALL_N   = SMALL_ENTRIES_DEF;
	localparam int LARGE_N   = LARGE_ENTRIES_DEF;
	localparam int STRIDE    = 64;
	localparam int RANDOM_ITEMS = 360;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic strobe;
	rsp_t rsp;

	word_dictionary_decoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.strobe (strobe),
		.rsp    (rsp)
	);

	always #1 clk = ~clk;

	req_t pending_items [$];
	rsp_t expected_text [$];

	logic [7:0] small_bytes [0:SMALL_N*STRIDE-1];
	int         small_lens  [0:SMALL_N-1];
	logic [7:0] large_bytes [0:LARGE_N*STRIDE-1];
	int         large_lens  [0:LARGE_N-1];
	logic [7:0] word_buf    [0:MAX_BYTES-1];
	bit         prev_alnum = 1'b0;
	bit         text_started = 1'b0;

	int          plan_small_len  [0:SMALL_N-1];
	logic [63:0] plan_small_have [0:SMALL_N-1];
	int          plan_large_len  [0:LARGE_N-1];
	logic [63:0] plan_large_have [0:LARGE_N-1];
	int          word_list [$];

	int n_planned = 0;
	int n_accepted = 0;
	int n_loads = 0;
	int n_tokens = 0;
	int n_literals = 0;
	int n_checked = 0;
	int n_spaces = 0;
	int n_errors = 0;

	function automatic bit letter_or_digit(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic void put_text(input logic [7:0] b, input logic last);
		rsp_t r;
		r.out_byte = b;
		r.last_of_word = last;
		expected_text.push_back(r);
		text_started = 1'b1;
	endfunction

	function automatic void speak_word(input int len);
		bit cur;
		int i;
		cur = (len != 0) && letter_or_digit(word_buf[0]);
		if (prev_alnum && cur && text_started) begin
			put_text(SPACE_BYTE, 1'b0);
			n_spaces++;
		end
		for (i = 0; i < len; i++)
			put_text(word_buf[i], i == len - 1);
		prev_alnum = cur;
	endfunction

	function automatic void decode_item(input req_t r);
		int len;
		int idx;
		int pos;
		int i;
		len = r.entry_length;
		if (len > MAX_BYTES)
			len = MAX_BYTES;
		idx = r.entry_index;
		pos = r.byte_pos;
		case (r.req_type)
			REQ_LOAD: begin
				n_loads++;
				if (!r.dict_select) begin
					if (idx < SMALL_N) begin
						if (pos < MAX_BYTES)
							small_bytes[idx*STRIDE + pos] = r.data_byte;
						small_lens[idx] = len;
					end
				end else begin
					if (idx < LARGE_N) begin
						if (pos < MAX_BYTES)
							large_bytes[idx*STRIDE + pos] = r.data_byte;
						large_lens[idx] = len;
					end
				end
			end
			REQ_SMALL: begin
				n_tokens++;
				len = 0;
				if (idx < SMALL_N) begin
					len = small_lens[idx];
					for (i = 0; i < len; i++)
						word_buf[i] = small_bytes[idx*STRIDE + i];
				end
				speak_word(len);
			end
			REQ_LARGE: begin
				n_tokens++;
				len = 0;
				if (idx < LARGE_N) begin
					len = large_lens[idx];
					for (i = 0; i < len; i++)
						word_buf[i] = large_bytes[idx*STRIDE + i];
				end
				speak_word(len);
			end
			default: begin
				n_literals++;
				if (r.literal_first) begin
					word_buf[0] = r.data_byte;
					speak_word(1);
				end else begin
					put_text(r.data_byte, 1'b1);
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input rsp_t got, input rsp_t want);
		n_errors++;
		$display("MISMATCH at %0t: %s (got byte %02h last %0b, want byte %02h last %0b)",
			$realtime, what, got.out_byte, got.last_of_word, want.out_byte, want.last_of_word);
	endtask

	function automatic req_t noise_req();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	function automatic void add_item(input req_t r);
		int len;
		int idx;
		pending_items.push_back(r);
		n_planned++;
		if (r.req_type == REQ_LOAD) begin
			len = r.entry_length;
			if (len > MAX_BYTES)
				len = MAX_BYTES;
			idx = r.entry_index;
			if (!r.dict_select) begin
				if (idx < SMALL_N) begin
					if (r.byte_pos < MAX_BYTES)
						plan_small_have[idx][r.byte_pos] = 1'b1;
					plan_small_len[idx] = len;
				end
			end else begin
				if (r.byte_pos < MAX_BYTES)
					plan_large_have[idx][r.byte_pos] = 1'b1;
				plan_large_len[idx] = len;
			end
		end
	endfunction

	function automatic bit token_ready(input bit use_large, input int idx);
		int len;
		logic [63:0] have;
		logic [63:0] need;
		len = use_large ? plan_large_len[idx] : plan_small_len[idx];
		have = use_large ? plan_large_have[idx] : plan_small_have[idx];
		need = (64'd1 << len) - 64'd1;
		return len >= 0 && (have & need) == need;
	endfunction

	function automatic void add_load(input bit sel, input int idx, input int pos, input int len,
			input logic [7:0] data);
		req_t r;
		r = noise_req();
		r.req_type = REQ_LOAD;
		r.dict_select = sel;
		r.entry_index = IDX_W'(idx);
		r.byte_pos = POS_W'(pos);
		r.entry_length = LEN_W'(len);
		r.data_byte = data;
		add_item(r);
	endfunction

	function automatic void add_token(input logic [1:0] kind, input int idx);
		req_t r;
		r = noise_req();
		r.req_type = kind;
		r.entry_index = IDX_W'(idx);
		add_item(r);
	endfunction

	function automatic void add_literal(input logic [7:0] data, input bit first, input bit last);
		req_t r;
		r = noise_req();
		r.req_type = REQ_LITERAL;
		r.data_byte = data;
		r.literal_first = first;
		r.literal_last = last;
		add_item(r);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0, 1, 2: return 8'(8'h61 + $urandom_range(25));
			3, 4: return 8'(8'h41 + $urandom_range(25));
			5, 6: return 8'(8'h30 + $urandom_range(9));
			7: begin
				case ($urandom_range(9))
					0: return 8'h00;
					1: return 8'hff;
					2: return 8'h2f;
					3: return 8'h3a;
					4: return 8'h40;
					5: return 8'h5b;
					6: return 8'h60;
					7: return 8'h7b;
					8: return 8'h20;
					default: return 8'h2e;
				endcase
			end
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void add_word(input bit sel, input int idx, input int len);
		int pos;
		if (len == 0) begin
			add_load(sel, idx, $urandom_range(63), 0, pick_byte());
		end else begin
			for (pos = 0; pos < len; pos++)
				add_load(sel, idx, pos, len, pick_byte());
		end
		word_list.push_back(sel * LARGE_N + idx);
	endfunction

	function automatic int pick_length();
		int roll;
		roll = $urandom_range(99);
		if (roll < 85)
			return $urandom_range(6, 1);
		if (roll < 95)
			return $urandom_range(12);
		if ($urandom_range(3) == 0)
			return MAX_BYTES;
		return $urandom_range(MAX_BYTES, 13);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				decode_item(req);
				n_accepted++;
			end
			if (!start || !busy) begin
				if (pending_items.size() != 0 &&
						((n_accepted >= 150 && n_accepted < 260) || $urandom_range(99) >= 21)) begin
					start <= 1'b1;
					req <= pending_items.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && strobe) begin
			if (expected_text.size() == 0) begin
				want = '0;
				report_mismatch("result with nothing expected", rsp, want);
			end else begin
				want = expected_text.pop_front();
				n_checked++;
				if (rsp.out_byte !== want.out_byte)
					report_mismatch("out_byte differs", rsp, want);
				if (rsp.last_of_word !== want.last_of_word)
					report_mismatch("last_of_word differs", rsp, want);
			end
		end
	end

	initial begin
		#1000000;
		$display("word_dictionary_decoder_top regression: fail");
		$finish;
	end

	initial begin
		int i;
		int target;
		int key;
		int len;
		int k;
		for (i = 0; i < SMALL_N; i++) begin
			plan_small_len[i] = -1;
			plan_small_have[i] = '0;
		end
		for (i = 0; i < LARGE_N; i++) begin
			plan_large_len[i] = -1;
			plan_large_have[i] = '0;
		end

		add_literal("A", 1'b1, 1'b1);
		add_literal("b", 1'b1, 1'b1);
		add_literal("9", 1'b1, 1'b0);
		add_literal(8'hff, 1'b0, 1'b1);
		add_literal(".", 1'b1, 1'b1);
		add_load(1'b0, 0, 0, 2, "h");
		add_load(1'b0, 0, 1, 2, "i");
		add_load(1'b1, LARGE_N - 1, 0, 1, "0");
		add_load(1'b0, SMALL_N - 1, 63, 0, 8'hff);
		add_load(1'b0, SMALL_N, 0, 5, "x");
		add_token(REQ_SMALL, 0);
		add_token(REQ_LARGE, LARGE_N - 1);
		add_token(REQ_SMALL, SMALL_N - 1);
		add_token(REQ_SMALL, 4095);
		add_token(REQ_LARGE, LARGE_N - 1);
		add_literal("Z", 1'b1, 1'b1);
		add_literal(8'h00, 1'b1, 1'b1);

		target = n_planned + RANDOM_ITEMS;
		add_word(1'b1, LARGE_N - 2, MAX_BYTES);
		add_literal("q", 1'b1, 1'b1);
		add_token(REQ_LARGE, LARGE_N - 2);
		while (n_planned < target) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					if ($urandom_range(1))
						add_word(1'b1, $urandom_range(LARGE_N - 1), pick_length());
					else
						add_word(1'b0, $urandom_range(SMALL_N - 1), pick_length());
				end
				8, 9, 10, 11, 12, 13, 14: begin
					key = (word_list.size() != 0) ? word_list[$urandom_range(word_list.size() - 1)]
						: -1;
					if (key >= 0 && token_ready(key >= LARGE_N, key % LARGE_N))
						add_token(key >= LARGE_N ? REQ_LARGE : REQ_SMALL, key % LARGE_N);
					else
						add_literal(pick_byte(), 1'b1, 1'b1);
				end
				15, 16, 17: begin
					len = $urandom_range(5, 1);
					for (k = 0; k < len; k++)
						add_literal(pick_byte(), k == 0, k == len - 1);
				end
				default: begin
					case ($urandom_range(3))
						0: add_load(1'($urandom_range(1)), $urandom_range(4095),
							$urandom_range(63), $urandom_range(63), 8'($urandom_range(255)));
						1: add_token(REQ_SMALL, $urandom_range(4095, SMALL_N));
						2: add_literal(8'($urandom_range(255)), 1'($urandom_range(1)),
							1'($urandom_range(1)));
						default: add_load(1'b0, $urandom_range(4095, SMALL_N), $urandom_range(63),
							$urandom_range(63), 8'($urandom_range(255)));
					endcase
				end
			endcase
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || start)
			@(posedge clk);
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Covered %0d items: %0d loads, %0d tokens, %0d literal bytes.",
			n_accepted, n_loads, n_tokens, n_literals);
		$display("Checked %0d decoded bytes, %0d of them inserted spaces; %0d mismatches.",
			n_checked, n_spaces, n_errors);
		if (n_errors == 0)
			$display("word_dictionary_decoder_top regression: pass");
		else
			$display("word_dictionary_decoder_top regression: fail");
		$finish;
	end

endmodule
